>>> src/bap_pkg.sv
// Shared constants and types for the 2x2 block-average pixelate block.
package bap_pkg;

    // Field widths
    localparam int PIX_W   = 8;
    localparam int CFG_W   = 9;
    localparam int COORD_W = 9;
    localparam int SUM_W   = PIX_W + 1;

    // Stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FIELD_W = PIX_W + 2 * COORD_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Default size limits
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    // Configuration register map
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_PAIRS  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT_PAIRS = 1'd1;

    localparam logic [CFG_W-1:0] WIDTH_PAIRS_RST  = 9'd256;
    localparam logic [CFG_W-1:0] HEIGHT_PAIRS_RST = 9'd256;

    // Block queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // One finished 2x2 block: average, bottom-right coordinate and last-block flag
    typedef struct packed {
        logic [PIX_W-1:0]   avg;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } t_blk;

endpackage

>>> src/block_average_pixelate_2x2.sv
// Top level of the 2x2 block-average pixelate block.
//
// Channel   Dir  Handshake                    Content (low bit first)
// s_axis    in   s_axis_tvalid/tready         tdata: pixel_in[7:0]
// m_axis    out  m_axis_tvalid/tready         tdata: pixel_out[7:0], out_row[16:8],
//                                             out_col[25:17], zero pad;
//                                             tlast: image_done; tuser: block_done
// cfg       in   i_cfg_we                     addr 0 width_pairs, addr 1 height_pairs
//
// The input takes one pixel per cycle while the block queue has room. Each odd-column
// pixel of an odd row yields four results and the output port moves one result per
// cycle while m_axis_tready is high, so a sustained odd row is paced by the output. The
// first result of a block passes through the line read and sum stage, the block queue
// and the output register. Reset clears counters and sets both sizes to 256; the line
// buffer is not cleared. The input stalls while three or more blocks wait in the queue.
module block_average_pixelate_2x2 #(
    parameter int MAX_WIDTH  = bap_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bap_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bap_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [bap_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bap_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // pixel_in
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bap_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // pixel_out, out_row, out_col
    output logic                            m_axis_tlast,   // image_done
    output logic                            m_axis_tuser    // block_done
);
    import bap_pkg::*;

    logic q_push;
    t_blk q_in;
    logic q_pop;
    logic q_valid;
    t_blk q_head;
    logic q_afull;

    bap_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_pixel     (s_axis_tdata[PIX_W-1:0]),
        .i_q_afull   (q_afull),
        .o_push      (q_push),
        .o_entry     (q_in)
    );

    bap_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head),
        .o_afull (q_afull)
    );

    bap_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (q_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tlast   (m_axis_tlast),
        .o_tuser   (m_axis_tuser)
    );

endmodule

>>> src/bap_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bap_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    i_clk,
    i_we,
    i_waddr,
    i_wdata,
    i_raddr,
    o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             i_clk;
    input  logic             i_we;
    input  logic [AW-1:0]    i_waddr;
    input  logic [WIDTH-1:0] i_wdata;
    input  logic [AW-1:0]    i_raddr;
    output logic [WIDTH-1:0] o_rdata;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bap_front.sv
// Front end: config registers, raster counters, line buffer and block sum.
module bap_front #(
    parameter int MAX_WIDTH  = bap_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bap_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bap_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bap_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [bap_pkg::PIX_W-1:0]      i_pixel,
    input  logic                           i_q_afull,
    output logic                           o_push,
    output bap_pkg::t_blk                  o_entry
);
    import bap_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WC_W = (CW + 1 > CFG_W + 1) ? CW + 1 : CFG_W + 1;
    localparam int HC_W = (RW + 1 > CFG_W + 1) ? RW + 1 : CFG_W + 1;
    localparam logic [WC_W-1:0] W_CAP = WC_W'(MAX_WIDTH / 2);
    localparam logic [HC_W-1:0] H_CAP = HC_W'(MAX_HEIGHT / 2);

    logic [CFG_W-1:0] r_width_pairs;
    logic [CFG_W-1:0] r_height_pairs;
    logic [CW-1:0]    r_col;
    logic [CW-1:0]    n_col;
    logic [RW-1:0]    r_row;
    logic [RW-1:0]    n_row;
    logic [PIX_W-1:0] r_held;

    logic             r_s1_valid;
    logic [SUM_W-1:0] r_s1_sum;
    logic [COORD_W-1:0] r_s1_row;
    logic [COORD_W-1:0] r_s1_col;
    logic             r_s1_last;

    logic [WC_W-1:0]  wp_ext;
    logic [WC_W-1:0]  w_pairs;
    logic [WC_W-1:0]  img_width;
    logic [WC_W-1:0]  col_inc;
    logic [HC_W-1:0]  hp_ext;
    logic [HC_W-1:0]  h_pairs;
    logic [HC_W-1:0]  img_height;
    logic [HC_W-1:0]  row_ext;
    logic [HC_W-1:0]  row_inc;
    logic             col_wrap;
    logic             row_end;
    logic             row_over;
    logic             accept;
    logic             line_we;
    logic             emit;
    logic [AW-1:0]    slot;
    logic [SUM_W-1:0] pair_sum;
    logic [SUM_W-1:0] line_rdata;
    logic [SUM_W:0]   blk_total;

    // Config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_pairs  <= WIDTH_PAIRS_RST;
            r_height_pairs <= HEIGHT_PAIRS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_WIDTH_PAIRS:  r_width_pairs  <= i_cfg_wdata;
                REG_HEIGHT_PAIRS: r_height_pairs <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective size: zero acts as one; width clamps to the line buffer, height to MAX_HEIGHT/2
    assign wp_ext     = WC_W'(r_width_pairs);
    assign w_pairs    = (wp_ext == '0) ? WC_W'(1) : ((wp_ext > W_CAP) ? W_CAP : wp_ext);
    assign img_width  = w_pairs << 1;
    assign hp_ext     = HC_W'(r_height_pairs);
    assign h_pairs    = (hp_ext == '0) ? HC_W'(1) : ((hp_ext > H_CAP) ? H_CAP : hp_ext);
    assign img_height = h_pairs << 1;

    // Raster position bookkeeping
    assign col_inc  = WC_W'(r_col) + WC_W'(1);
    assign row_ext  = HC_W'(r_row);
    assign row_inc  = row_ext + HC_W'(1);
    assign col_wrap = (col_inc >= img_width);
    assign row_end  = (row_inc >= img_height);
    assign row_over = (row_ext >= img_height);

    always_comb begin
        if (col_wrap) begin
            n_col = '0;
            n_row = row_end ? '0 : RW'(row_inc);
        end else begin
            n_col = CW'(col_inc);
            n_row = row_over ? '0 : r_row;
        end
    end

    assign o_ready = !i_q_afull;
    assign accept  = i_valid && o_ready;
    assign slot    = AW'(r_col >> 1);
    assign pair_sum = SUM_W'(r_held) + SUM_W'(i_pixel);
    assign line_we = accept && r_col[0] && !r_row[0];
    assign emit    = accept && r_col[0] && r_row[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Left pixel of each pair
    always_ff @(posedge i_clk) begin
        if (accept && !r_col[0]) begin
            r_held <= i_pixel;
        end
    end

    // Pair sums of the top row of each block
    bap_ram #(
        .WIDTH (SUM_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (slot),
        .i_wdata (pair_sum),
        .i_raddr (slot),
        .o_rdata (line_rdata)
    );

    // Stage 1: wait for the line read, then add the top pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s1_sum  <= pair_sum;
            r_s1_row  <= COORD_W'(r_row);
            r_s1_col  <= COORD_W'(r_col);
            r_s1_last <= col_wrap && row_end;
        end
    end

    assign blk_total     = (SUM_W + 1)'(line_rdata) + (SUM_W + 1)'(r_s1_sum);
    assign o_push        = r_s1_valid;
    assign o_entry.avg   = blk_total[SUM_W:2];
    assign o_entry.row   = r_s1_row;
    assign o_entry.col   = r_s1_col;
    assign o_entry.last  = r_s1_last;

endmodule

>>> src/bap_fifo.sv
// Short queue of finished blocks between front and back.
module bap_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bap_pkg::t_blk i_entry,
    input  logic          i_pop,
    output logic          o_valid,
    output bap_pkg::t_blk o_head,
    output logic          o_afull
);
    import bap_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_blk          r_buf [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [NW-1:0] r_count;

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        ptr_next = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_next(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_next(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + NW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_buf[r_rptr];
    // One stage of the front may still be in flight, so leave a slot for it
    assign o_afull = (r_count >= NW'(QUEUE_DEPTH - 1));

endmodule

>>> src/bap_back.sv
// Back end: replays each block average for its four pixels into the output register.
module bap_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  bap_pkg::t_blk                    i_q_head,
    output logic                             o_pop,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    output logic [bap_pkg::OUT_TDATA_W-1:0]  o_tdata,
    output logic                             o_tlast,
    output logic                             o_tuser
);
    import bap_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - OUT_FIELD_W;

    // Output order within a block
    localparam logic [1:0] PH_TL = 2'd0;
    localparam logic [1:0] PH_BL = 2'd1;
    localparam logic [1:0] PH_TR = 2'd2;
    localparam logic [1:0] PH_BR = 2'd3;

    logic [1:0]         r_phase;
    logic               r_tvalid;
    logic [PIX_W-1:0]   r_pix;
    logic [COORD_W-1:0] r_row;
    logic [COORD_W-1:0] r_col;
    logic               r_block_done;
    logic               r_image_done;

    logic               load;
    logic [COORD_W-1:0] top_row;
    logic [COORD_W-1:0] left_col;
    logic [COORD_W-1:0] n_row;
    logic [COORD_W-1:0] n_col;
    logic               n_block_done;
    logic               n_image_done;

    assign load  = i_q_valid && (!r_tvalid || i_tready);
    assign o_pop = load && (r_phase == PH_BR);

    // Stored coordinate is the odd (bottom-right) one; clear bit 0 for top/left
    assign top_row  = {i_q_head.row[COORD_W-1:1], 1'b0};
    assign left_col = {i_q_head.col[COORD_W-1:1], 1'b0};

    always_comb begin
        n_block_done = 1'b0;
        n_image_done = 1'b0;
        case (r_phase)
            PH_TL: begin
                n_row = top_row;
                n_col = left_col;
            end
            PH_BL: begin
                n_row = i_q_head.row;
                n_col = left_col;
            end
            PH_TR: begin
                n_row = top_row;
                n_col = i_q_head.col;
            end
            PH_BR: begin
                n_row        = i_q_head.row;
                n_col        = i_q_head.col;
                n_block_done = 1'b1;
                n_image_done = i_q_head.last;
            end
            default: begin
                n_row = top_row;
                n_col = left_col;
            end
        endcase
    end

    // Phase and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TL;
            r_tvalid <= 1'b0;
        end else if (load) begin
            r_phase  <= r_phase + 2'd1;
            r_tvalid <= 1'b1;
        end else if (i_tready) begin
            r_tvalid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pix        <= i_q_head.avg;
            r_row        <= n_row;
            r_col        <= n_col;
            r_block_done <= n_block_done;
            r_image_done <= n_image_done;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = {{PAD_W{1'b0}}, r_col, r_row, r_pix};
    assign o_tlast  = r_image_done;
    assign o_tuser  = r_block_done;

endmodule
